// ===== src/peavg_pkg.sv =====
// Shared types and constants for the pulse event peak/average block.
// No dependencies; every other file in src except peavg_fifo imports this package.
package peavg_pkg;

    localparam int SAMPLE_W = 11;
    localparam int TICK_W   = 32;
    localparam int KILL_W   = 8;
    localparam int CMD_W    = 3;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 11'd1024;
    localparam logic [TICK_W-1:0]   TPS_RESET  = 32'd32768;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_END     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PROCESS = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEC  = 4'b0010,
        ST_AVG  = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

endpackage

// ===== src/pulse_event_peak_average.sv =====
// Top level of the pulse event peak/average block.
// Depends on peavg_pkg, peavg_front, peavg_fifo, peavg_back and peavg_div.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    tuser: cmd; tdata: sample
//  m_        out        m_tvalid/m_tready    tdata: event record
//  cfg_      in         cfg_wr_en            cfg_wr_data: ticks_per_second
//
// Clear, start, sample, tick and end take one cycle each and never stall
// while the two-entry record queue has room. A process command takes the back
// end through its seconds division and, with samples, an average division: the
// shared radix-2 divider makes 32 steps for the seconds and 32 for the average.
// Reset (aresetn low, synchronous) clears all event state and sets the tick
// rate to 32768. s_tready drops only while the record queue is full.
module pulse_event_peak_average
    import peavg_pkg::*;
#(
    parameter int AVG_SAMPLES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,     // [2:0] cmd
    input  logic [15:0] s_tdata,     // [10:0] sample, [15:11] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [7:0] kill_number, [39:8] length_seconds,
                                     // [50:40] peak, [61:51] average,
                                     // [62] clipped, [63] zero
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    localparam int CNT_W   = $clog2(AVG_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_W + CNT_W;
    localparam int ENTRY_W = KILL_W + TICK_W + SUM_W + CNT_W + SAMPLE_W + 2;

    logic [TICK_W-1:0]  tps_reg;
    logic               in_fire;
    logic               q_full;
    logic               q_push;
    logic [ENTRY_W-1:0] q_push_data;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_data;
    logic               q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= TPS_RESET;
        end else if (cfg_wr_en) begin
            tps_reg <= cfg_wr_data;
        end
    end

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    peavg_front #(
        .AVG_SAMPLES (AVG_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .cmd       (s_tuser),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .push      (q_push),
        .push_data (q_push_data)
    );

    peavg_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head_data (q_data)
    );

    peavg_back #(
        .CNT_W   (CNT_W),
        .SUM_W   (SUM_W),
        .ENTRY_W (ENTRY_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ticks_per_second (tps_reg),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .q_pop            (q_pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule

// ===== src/peavg_fifo.sv =====
// Two-entry queue that carries snapshot records from the front to the back.
// Depends on nothing but its WIDTH parameter.
module peavg_fifo #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign full      = count_reg[1];
    assign not_empty = (count_reg != 2'd0);
    assign head_data = mem[rd_ptr_reg];

endmodule

// ===== src/peavg_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses peavg_pkg for the operand width. A zero divisor yields all ones.
module peavg_div
    import peavg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TICK_W-1:0] dividend,
    input  logic [TICK_W-1:0] divisor,
    output logic              done,
    output logic [TICK_W-1:0] quotient
);

    localparam int CNT_W = $clog2(TICK_W);

    logic [TICK_W:0]   rem_reg;
    logic [TICK_W-1:0] quo_reg;
    logic [TICK_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [TICK_W:0] trial;
    logic            fits;

    assign trial = {rem_reg[TICK_W-1:0], quo_reg[TICK_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[TICK_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(TICK_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/peavg_front.sv =====
// Command front end: keeps the event state and snapshots it on process.
// Uses peavg_pkg for command codes and field widths.
module peavg_front
    import peavg_pkg::*;
#(
    parameter int AVG_SAMPLES = 16,
    parameter int CNT_W       = 5,
    parameter int SUM_W       = 16,
    parameter int ENTRY_W     = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                push,
    output logic [ENTRY_W-1:0]  push_data
);

    logic                active_reg;
    logic [TICK_W-1:0]   ticks_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [KILL_W-1:0]   event_reg;
    logic                cleared_reg;

    logic [KILL_W-1:0] event_next;

    assign event_next = event_reg + KILL_W'(1);
    assign push       = in_fire && (cmd == CMD_PROCESS);

    // Layout from the low bit: kill, ticks, sum, count, peak, clipped, clear-seen.
    assign push_data = {cleared_reg, (peak_reg == FULL_SCALE), peak_reg,
                        count_reg, sum_reg, ticks_reg, event_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            ticks_reg   <= '0;
            peak_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            event_reg   <= '0;
            cleared_reg <= 1'b0;
        end else if (in_fire) begin
            case (cmd)
                CMD_CLEAR: begin
                    active_reg  <= 1'b0;
                    ticks_reg   <= '0;
                    peak_reg    <= '0;
                    count_reg   <= '0;
                    sum_reg     <= '0;
                    cleared_reg <= 1'b1;
                end
                CMD_START: begin
                    active_reg <= 1'b1;
                    ticks_reg  <= '0;
                end
                CMD_SAMPLE: begin
                    if (count_reg < CNT_W'(AVG_SAMPLES)) begin
                        sum_reg   <= sum_reg + SUM_W'(sample);
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if (sample > peak_reg) begin
                        peak_reg <= sample;
                    end
                end
                CMD_TICK: begin
                    if (active_reg) begin
                        ticks_reg <= ticks_reg + TICK_W'(1);
                    end
                end
                CMD_END: begin
                    active_reg <= 1'b0;
                end
                CMD_PROCESS: begin
                    event_reg   <= event_next;
                    cleared_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/peavg_back.sv =====
// Back end: divides out seconds and, with samples, the average per queued record
// and holds the result for the output channel. Uses peavg_pkg and peavg_div.
module peavg_back
    import peavg_pkg::*;
#(
    parameter int CNT_W   = 5,
    parameter int SUM_W   = 16,
    parameter int ENTRY_W = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [TICK_W-1:0]  ticks_per_second,
    input  logic               q_valid,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata
);

    localparam int TICK_LO  = KILL_W;
    localparam int SUM_LO   = TICK_LO + TICK_W;
    localparam int CNT_LO   = SUM_LO + SUM_W;
    localparam int PEAK_LO  = CNT_LO + CNT_W;
    localparam int CLIP_BIT = PEAK_LO + SAMPLE_W;
    localparam int CLR_BIT  = CLIP_BIT + 1;

    back_state_t state_reg;

    logic [KILL_W-1:0]   kill_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic                clip_reg;
    logic [TICK_W-1:0]   secs_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic                out_valid_reg;
    logic [63:0]         out_data_reg;

    logic              div_start;
    logic [TICK_W-1:0] div_dividend;
    logic [TICK_W-1:0] div_divisor;
    logic              div_done;
    logic [TICK_W-1:0] div_quotient;
    logic              out_free;
    logic              load_out;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !out_valid_reg || m_tready;
    assign load_out = (state_reg == ST_DONE) && out_free;

    // One shared divider: seconds first, then the average when samples exist.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = q_data[SUM_LO-1:TICK_LO];
        div_divisor  = ticks_per_second;
        if (state_reg == ST_IDLE) begin
            div_start = q_valid;
        end else if (state_reg == ST_SEC) begin
            div_start    = div_done && (count_reg != '0);
            div_dividend = TICK_W'(sum_reg);
            div_divisor  = TICK_W'(count_reg);
        end
    end

    peavg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kill_reg  <= q_data[TICK_LO-1:0];
            sum_reg   <= q_data[CNT_LO-1:SUM_LO];
            count_reg <= q_data[PEAK_LO-1:CNT_LO];
            peak_reg  <= q_data[CLIP_BIT-1:PEAK_LO];
            clip_reg  <= q_data[CLIP_BIT];
        end
        if ((state_reg == ST_SEC) && div_done) begin
            secs_reg <= div_quotient;
        end
        if (load_out) begin
            out_data_reg <= {1'b0, clip_reg, avg_reg, peak_reg, secs_reg, kill_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        // A clear since the previous record drops the held average.
                        if (q_data[CLR_BIT]) begin
                            avg_reg <= '0;
                        end
                        state_reg <= ST_SEC;
                    end
                end
                ST_SEC: begin
                    if (div_done) begin
                        state_reg <= (count_reg != '0) ? ST_AVG : ST_DONE;
                    end
                end
                ST_AVG: begin
                    if (div_done) begin
                        avg_reg   <= div_quotient[SAMPLE_W-1:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
